@@ src/clock_hand_stepper_positioner_defines.svh @@
// Assertion macros for the RTL.
`ifndef CLOCK_HAND_STEPPER_POSITIONER_DEFINES_SVH
`define CLOCK_HAND_STEPPER_POSITIONER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define CHSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked while out of reset.
`define CHSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/chsp_pkg.sv @@
`timescale 1ns / 1ps

package chsp_pkg;

    localparam int POS_W       = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] previous_hour;
    } t_in;

    typedef struct packed {
        logic [1:0]  motor;
        logic        direction;
        logic [11:0] step_count;
        logic        last;
    } t_out;

    // One classified update, handed from the front end to the back end.
    typedef struct packed {
        logic plate_first;
        logic crossing;
        logic plate_left;
        t_pos hour_target;
        t_pos minute_target;
    } t_job;

    localparam logic [1:0]  MOTOR_PLATE  = 2'd0;
    localparam logic [1:0]  MOTOR_HOUR   = 2'd1;
    localparam logic [1:0]  MOTOR_MINUTE = 2'd2;
    localparam logic [11:0] COUNT_MAX    = 12'd4095;
    localparam logic [11:0] PLATE_RESET  = 12'd1100;
    localparam logic [4:0]  HALF_DAY     = 5'd12;

    // Step position of the hour hand at the start of the given hour.
    function automatic t_pos hour_base(input logic [4:0] hour);
        t_pos v;
        unique case (hour)
            5'd0:  v = -13'sd120;
            5'd1:  v = 13'sd30;
            5'd2:  v = 13'sd300;
            5'd3:  v = 13'sd550;
            5'd4:  v = 13'sd850;
            5'd5:  v = 13'sd1180;
            5'd6:  v = 13'sd1520;
            5'd7:  v = 13'sd1870;
            5'd8:  v = 13'sd2190;
            5'd9:  v = 13'sd2500;
            5'd10: v = 13'sd2770;
            5'd11: v = 13'sd3040;
            5'd12: v = 13'sd0;
            5'd13: v = 13'sd200;
            5'd14: v = 13'sd400;
            5'd15: v = 13'sd640;
            5'd16: v = 13'sd940;
            5'd17: v = 13'sd1280;
            5'd18: v = 13'sd1610;
            5'd19: v = 13'sd1930;
            5'd20: v = 13'sd2280;
            5'd21: v = 13'sd2580;
            5'd22: v = 13'sd2830;
            5'd23: v = 13'sd3090;
            5'd24: v = 13'sd3240;
            default: v = 13'sd3450;
        endcase
        return v;
    endfunction

    // Steps per minute within the given hour.
    function automatic logic [2:0] hour_rate(input logic [4:0] hour);
        logic [2:0] v;
        unique case (hour)
            5'd0:  v = 3'd2;
            5'd1:  v = 3'd4;
            5'd2:  v = 3'd4;
            5'd3:  v = 3'd5;
            5'd4:  v = 3'd5;
            5'd5:  v = 3'd5;
            5'd6:  v = 3'd5;
            5'd7:  v = 3'd5;
            5'd8:  v = 3'd5;
            5'd9:  v = 3'd4;
            5'd10: v = 3'd4;
            5'd11: v = 3'd3;
            5'd12: v = 3'd0;
            5'd13: v = 3'd3;
            5'd14: v = 3'd4;
            5'd15: v = 3'd5;
            5'd16: v = 3'd5;
            5'd17: v = 3'd5;
            5'd18: v = 3'd5;
            5'd19: v = 3'd5;
            5'd20: v = 3'd5;
            5'd21: v = 3'd4;
            5'd22: v = 3'd4;
            5'd23: v = 3'd2;
            5'd24: v = 3'd3;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // Step position of the minute hand at the start of a ten-minute span.
    function automatic t_pos minute_base(input logic [2:0] tens);
        t_pos v;
        unique case (tens)
            3'd0: v = 13'sd0;
            3'd1: v = 13'sd470;
            3'd2: v = 13'sd920;
            3'd3: v = 13'sd1370;
            3'd4: v = 13'sd1820;
            3'd5: v = 13'sd2270;
            default: v = 13'sd2770;
        endcase
        return v;
    endfunction

    // Steps per minute within a ten-minute span.
    function automatic logic [5:0] minute_rate(input logic [2:0] tens);
        logic [5:0] v;
        unique case (tens)
            3'd0: v = 6'd47;
            3'd1: v = 6'd45;
            3'd2: v = 6'd45;
            3'd3: v = 6'd45;
            3'd4: v = 6'd45;
            3'd5: v = 6'd50;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/chsp_front.sv @@
`timescale 1ns / 1ps

module chsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  chsp_pkg::t_in   i_in_data,
    input  logic            i_q_full,
    output logic            o_push,
    output chsp_pkg::t_job  o_job
);

    logic              r_first;
    logic              w_hour_pm;
    logic              w_prev_pm;
    logic [2:0]        w_hour_rate;
    logic [8:0]        w_hour_frac;
    logic [2:0]        w_tens;
    logic [5:0]        w_tens_min;
    logic [3:0]        w_units;
    logic [5:0]        w_min_rate;
    logic [9:0]        w_min_frac;
    chsp_pkg::t_pos    w_hour_frac_pos;
    chsp_pkg::t_pos    w_min_frac_pos;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign w_hour_pm = i_in_data.hour >= chsp_pkg::HALF_DAY;
    assign w_prev_pm = i_in_data.previous_hour >= chsp_pkg::HALF_DAY;

    assign w_hour_rate     = chsp_pkg::hour_rate(i_in_data.hour);
    assign w_hour_frac     = {6'd0, w_hour_rate} * {3'd0, i_in_data.minute};
    assign w_hour_frac_pos = {4'd0, w_hour_frac};

    // Ten-minute span found by a compare chain; the units follow by subtraction.
    always_comb begin
        if (i_in_data.minute >= 6'd60) begin
            w_tens = 3'd6;
        end else if (i_in_data.minute >= 6'd50) begin
            w_tens = 3'd5;
        end else if (i_in_data.minute >= 6'd40) begin
            w_tens = 3'd4;
        end else if (i_in_data.minute >= 6'd30) begin
            w_tens = 3'd3;
        end else if (i_in_data.minute >= 6'd20) begin
            w_tens = 3'd2;
        end else if (i_in_data.minute >= 6'd10) begin
            w_tens = 3'd1;
        end else begin
            w_tens = 3'd0;
        end
    end

    assign w_tens_min     = {3'd0, w_tens} * 6'd10;
    assign w_units        = 4'(i_in_data.minute - w_tens_min);
    assign w_min_rate     = chsp_pkg::minute_rate(w_tens);
    assign w_min_frac     = {4'd0, w_min_rate} * {6'd0, w_units};
    assign w_min_frac_pos = {3'd0, w_min_frac};

    always_comb begin
        o_job.plate_first   = r_first && !w_hour_pm;
        o_job.crossing      = w_hour_pm != w_prev_pm;
        o_job.plate_left    = w_hour_pm;
        o_job.hour_target   = chsp_pkg::hour_base(i_in_data.hour) + w_hour_frac_pos;
        o_job.minute_target = chsp_pkg::minute_base(w_tens) + w_min_frac_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_push) begin
            r_first <= 1'b0;
        end
    end

endmodule

@@ src/chsp_queue.sv @@
`timescale 1ns / 1ps

module chsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  chsp_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output chsp_pkg::t_job  o_job
);

    chsp_pkg::t_job                  r_mem [chsp_pkg::QUEUE_DEPTH];
    logic [chsp_pkg::QPTR_W-1:0]     r_wptr;
    logic [chsp_pkg::QPTR_W-1:0]     r_rptr;
    logic [chsp_pkg::QCNT_W-1:0]     r_count;

    assign o_full  = r_count == chsp_pkg::QCNT_W'(chsp_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/chsp_back.sv @@
`timescale 1ns / 1ps

module chsp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  chsp_pkg::t_job  i_q_job,
    output logic            o_pop,
    input  logic [11:0]     i_plate_steps,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output chsp_pkg::t_out  o_out_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIRST  = 3'd1;
    localparam logic [2:0] S_REWIND = 3'd2;
    localparam logic [2:0] S_PLATE  = 3'd3;
    localparam logic [2:0] S_HOUR   = 3'd4;
    localparam logic [2:0] S_MINUTE = 3'd5;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    chsp_pkg::t_job  r_job;
    chsp_pkg::t_job  n_job;
    chsp_pkg::t_pos  r_hour_pos;
    chsp_pkg::t_pos  n_hour_pos;
    chsp_pkg::t_pos  r_min_pos;
    chsp_pkg::t_pos  n_min_pos;
    logic            r_out_valid;
    logic            n_out_valid;
    chsp_pkg::t_out  r_out;
    chsp_pkg::t_out  n_out;

    logic            w_adv;
    chsp_pkg::t_pos  w_tgt;
    chsp_pkg::t_pos  w_pos;
    logic [13:0]     w_delta;
    logic [13:0]     w_mag;
    logic [11:0]     w_sat;
    logic [13:0]     w_issued;
    logic [13:0]     w_sum;
    chsp_pkg::t_pos  w_new_pos;

    function automatic logic [2:0] start_state(input chsp_pkg::t_job job);
        logic [2:0] s;
        if (job.plate_first) begin
            s = S_FIRST;
        end else if (job.crossing) begin
            s = S_REWIND;
        end else begin
            s = S_HOUR;
        end
        return s;
    endfunction

    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Hand move: minute hand in S_MINUTE, else hour hand (to zero on rewind).
    always_comb begin
        case (r_state)
            S_MINUTE: begin
                w_tgt = r_job.minute_target;
                w_pos = r_min_pos;
            end
            S_REWIND: begin
                w_tgt = '0;
                w_pos = r_hour_pos;
            end
            default: begin
                w_tgt = r_job.hour_target;
                w_pos = r_hour_pos;
            end
        endcase
    end

    assign w_delta   = {w_tgt[12], w_tgt} - {w_pos[12], w_pos};
    assign w_mag     = w_delta[13] ? (~w_delta + 14'd1) : w_delta;
    assign w_sat     = (w_mag > {2'b00, chsp_pkg::COUNT_MAX}) ? chsp_pkg::COUNT_MAX : w_mag[11:0];
    assign w_issued  = w_delta[13] ? (14'd0 - {2'b00, w_sat}) : {2'b00, w_sat};
    assign w_sum     = {w_pos[12], w_pos} + w_issued;
    assign w_new_pos = w_sum[12:0];

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_hour_pos  = r_hour_pos;
        n_min_pos   = r_min_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_job   = i_q_job;
                    n_state = start_state(i_q_job);
                end
            end
            S_FIRST: begin
                if (w_adv) begin
                    n_out_valid = 1'b1;
                    n_out       = '{chsp_pkg::MOTOR_PLATE, 1'b0, i_plate_steps, 1'b0};
                    n_state     = r_job.crossing ? S_REWIND : S_HOUR;
                end
            end
            S_REWIND: begin
                if (w_adv) begin
                    n_out_valid = 1'b1;
                    n_out       = '{chsp_pkg::MOTOR_HOUR, !w_delta[13], w_sat, 1'b0};
                    n_hour_pos  = '0;
                    n_state     = S_PLATE;
                end
            end
            S_PLATE: begin
                if (w_adv) begin
                    n_out_valid = 1'b1;
                    n_out       = '{chsp_pkg::MOTOR_PLATE, r_job.plate_left, i_plate_steps,
                                    1'b0};
                    n_state     = S_HOUR;
                end
            end
            S_HOUR: begin
                if (w_adv) begin
                    n_out_valid = 1'b1;
                    n_out       = '{chsp_pkg::MOTOR_HOUR, !w_delta[13], w_sat, 1'b0};
                    n_hour_pos  = w_new_pos;
                    n_state     = S_MINUTE;
                end
            end
            S_MINUTE: begin
                if (w_adv) begin
                    n_out_valid = 1'b1;
                    n_out       = '{chsp_pkg::MOTOR_MINUTE, !w_delta[13], w_sat, 1'b1};
                    n_min_pos   = w_new_pos;
                    // Chain straight into the next queued update without a bubble.
                    if (i_q_valid) begin
                        o_pop   = 1'b1;
                        n_job   = i_q_job;
                        n_state = start_state(i_q_job);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hour_pos  <= '0;
            r_min_pos   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hour_pos  <= n_hour_pos;
            r_min_pos   <= n_min_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

endmodule

@@ src/clock_hand_stepper_positioner.sv @@
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------
// in       | i_in_valid / o_in_ready    | i_in_data  (hour, minute, prev hr)
// out      | o_out_valid / i_out_ready  | o_out_data (motor, dir, count, last)
// cfg      | i_cfg_we                   | i_cfg_wdata (plate step count)
//
// Each update yields two to five move commands, issued one per cycle while the output accepts them;
// an update popped while the sequencer is idle passes through its idle state first.
// A two-entry queue lets the front end take updates while commands drain.
// Reset is synchronous and returns both hand positions to zero and re-arms the first update.
// A stalled output holds its command and the sequencer waits.

`include "clock_hand_stepper_positioner_defines.svh"

module clock_hand_stepper_positioner (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  chsp_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output chsp_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic [11:0]     i_cfg_wdata
);

    logic [11:0]     r_plate_steps;
    logic            w_push;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_pop;
    chsp_pkg::t_job  w_front_job;
    chsp_pkg::t_job  w_q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plate_steps <= chsp_pkg::PLATE_RESET;
        end else if (i_cfg_we) begin
            r_plate_steps <= i_cfg_wdata;
        end
    end

    chsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    chsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    chsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_job       (w_q_job),
        .o_pop         (w_pop),
        .i_plate_steps (r_plate_steps),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

    `CHSP_ASSERT_IMPL(a_last_is_minute, i_clk, i_rst_n, o_out_valid && o_out_data.last, o_out_data.motor == chsp_pkg::MOTOR_MINUTE)
    `CHSP_ASSERT_IMPL(a_minute_is_last, i_clk, i_rst_n, o_out_valid && (o_out_data.motor == chsp_pkg::MOTOR_MINUTE), o_out_data.last)
    `CHSP_ASSERT_IMPL(a_pop_needs_entry, i_clk, i_rst_n, w_pop, w_q_valid)
    `CHSP_ASSERT_NEXT(a_push_fills_queue, i_clk, i_rst_n, w_push && !w_pop, w_q_valid)

endmodule
